### hdl/cfp_pkg.sv
package cfp_pkg;

    // Frame layout.
    localparam int HEADER_BYTES = 6;
    localparam int CRC_BYTES    = 2;

    // Buffer and payload sizing.
    localparam int MAX_PAYLOAD  = 16;
    localparam int BUFFER_DEPTH = 32;

    // CRC-16/MODBUS constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration register indexes.
    localparam logic [0:0] REG_SYNC_WORD   = 1'b0;
    localparam logic [0:0] REG_MAX_PAYLOAD = 1'b1;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_RD_SYNC,
        ST_CHK_SYNC,
        ST_RD_LEN,
        ST_CHK_LEN,
        ST_CRC,
        ST_RD_CRC,
        ST_CHK_CRC,
        ST_EMIT,
        ST_EMIT_WAIT
    } state_t;

    // Datapath opcodes, issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ_HDR,
        OP_READ_CRC,
        OP_CRC_INIT,
        OP_CRC_STEP,
        OP_DROP1,
        OP_DROP2,
        OP_DROP_FRAME,
        OP_EMIT_LOAD
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] offset;
    } cmd_t;

    typedef struct packed {
        logic sync_ok;
        logic len_ok;
        logic crc_ok;
        logic have_hdr;
        logic have_frame;
        logic have_two;
        logic crc_done;
        logic emit_last;
    } status_t;

    // One CRC-16/MODBUS update with one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] d);
        logic [15:0] c;
        c = crc_in ^ {8'h00, d};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) c = (c >> 1) ^ CRC_POLY;
            else      c = c >> 1;
        end
        return c;
    endfunction

endpackage

### hdl/cfp_stream_if.sv
interface cfp_stream_if #(parameter int WIDTH = 8);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/cfp_cfg_if.sv
interface cfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

### hdl/cfp_out_if.sv
interface cfp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] device_id;
    logic [7:0] function_code;
    logic [4:0] payload_length;
    logic [3:0] byte_index;
    logic [7:0] payload_byte;
    logic       frame_empty;
    logic       last;
    modport source (output valid, output device_id, output function_code,
                    output payload_length, output byte_index, output payload_byte,
                    output frame_empty, output last, input ready);
    modport sink   (input valid, input device_id, input function_code,
                    input payload_length, input byte_index, input payload_byte,
                    input frame_empty, input last, output ready);
endinterface

### hdl/cfp_ram.sv
module cfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

### hdl/cfp_datapath.sv
module cfp_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  cfp_pkg::cmd_t       cmd,
    output cfp_pkg::status_t    status,
    input  logic [7:0]          in_byte,
    input  logic [15:0]         sync_word,
    input  logic [4:0]          max_len,
    output logic [7:0]          device_id,
    output logic [7:0]          function_code,
    output logic [4:0]          payload_length,
    output logic [3:0]          byte_index,
    output logic [7:0]          payload_byte,
    output logic                frame_empty,
    output logic                last
);
    localparam int AW = $clog2(cfp_pkg::BUFFER_DEPTH);
    localparam int CW = AW + 1;
    localparam int LW = $clog2(cfp_pkg::MAX_PAYLOAD + 1);
    localparam int HEADER_SIZE_C = cfp_pkg::HEADER_BYTES;

    // The buffer is a circular window: head points at the oldest byte.
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [15:0]   crc_reg, crc_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [7:0]    b0_reg, b2_reg, b3_reg, b4_reg;
    logic [2:0]    rd_off_reg;
    logic [7:0]    rd_byte;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic          we;
    logic [15:0]   len_word;
    logic [15:0]   limit;
    logic [CW+1:0] frame_size;
    logic [LW-1:0] len_low;

    // Saturate the programmed limit to the parameter.
    assign limit = ({11'd0, max_len} > 16'(cfp_pkg::MAX_PAYLOAD)) ? 16'(cfp_pkg::MAX_PAYLOAD)
                                                                  : {11'd0, max_len};
    assign len_word   = {rd_byte, b4_reg};
    assign len_low    = b4_reg[LW-1:0];
    assign frame_size = (CW+2)'(HEADER_SIZE_C) + (CW+2)'(len_low) + (CW+2)'(2);

    // Buffer write: overwrite the oldest slot when full.
    assign we    = (cmd.op == cfp_pkg::OP_WRITE);
    assign waddr = head_reg + fill_reg[AW-1:0];
    assign raddr = head_reg + cmd.offset[AW-1:0];

    cfp_ram #(.WIDTH(8), .DEPTH(cfp_pkg::BUFFER_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (in_byte),
        .raddr (raddr),
        .rdata (rd_byte)
    );

    // Status flags for the controller.
    always_comb
    begin
        status.sync_ok    = ({rd_byte, b0_reg} == sync_word);
        status.len_ok     = (len_word <= limit);
        status.crc_ok     = ({rd_byte, b0_reg} == crc_reg);
        status.have_two   = (fill_reg >= CW'(2));
        status.have_hdr   = (fill_reg >= CW'(cfp_pkg::HEADER_BYTES));
        status.have_frame = ({2'b00, fill_reg} >= frame_size);
        status.crc_done   = ({2'b00, pos_reg} == frame_size - (CW+2)'(2));
        status.emit_last  = (len_low == '0) ||
                            ({{(CW-LW+1){1'b0}}, len_low} ==
                             {1'b0, pos_reg} - (CW+1)'(cfp_pkg::HEADER_BYTES));
    end

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        crc_next  = crc_reg;
        pos_next  = pos_reg;
        case (cmd.op)
            cfp_pkg::OP_WRITE:
            begin
                if (fill_reg == CW'(cfp_pkg::BUFFER_DEPTH)) head_next = head_reg + AW'(1);
                else                                        fill_next = fill_reg + CW'(1);
            end
            cfp_pkg::OP_DROP1:
            begin
                head_next = head_reg + AW'(1);
                fill_next = fill_reg - CW'(1);
            end
            cfp_pkg::OP_DROP2:
            begin
                head_next = head_reg + AW'(2);
                fill_next = fill_reg - CW'(2);
            end
            cfp_pkg::OP_DROP_FRAME:
            begin
                head_next = head_reg + frame_size[AW-1:0];
                fill_next = fill_reg - frame_size[CW-1:0];
            end
            cfp_pkg::OP_CRC_INIT:
            begin
                crc_next = cfp_pkg::CRC_INIT;
                pos_next = '0;
            end
            cfp_pkg::OP_CRC_STEP:
            begin
                crc_next = cfp_pkg::crc_byte(crc_reg, rd_byte);
                pos_next = pos_reg + CW'(1);
            end
            cfp_pkg::OP_EMIT_LOAD: pos_next = cmd.offset[CW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    // Capture header bytes as they are read back; the read data belongs to
    // the offset that was presented in the previous cycle.
    always_ff @(posedge clk)
    begin
        crc_reg    <= crc_next;
        pos_reg    <= pos_next;
        rd_off_reg <= cmd.offset[2:0];
        if (cmd.op == cfp_pkg::OP_READ_HDR)
        begin
            case (rd_off_reg)
                3'd0: b0_reg <= rd_byte;
                3'd2: b2_reg <= rd_byte;
                3'd3: b3_reg <= rd_byte;
                3'd4: b4_reg <= rd_byte;
                default: ;
            endcase
        end
        if (cmd.op == cfp_pkg::OP_READ_CRC) b0_reg <= rd_byte;
    end

    // Output payload of the current result.
    assign device_id      = b2_reg;
    assign function_code  = b3_reg;
    assign payload_length = 5'(len_low);
    assign frame_empty    = (len_low == '0);
    assign byte_index     = frame_empty ? 4'd0
                          : 4'(pos_reg - CW'(cfp_pkg::HEADER_BYTES + 1));
    assign payload_byte   = frame_empty ? 8'd0 : rd_byte;
    assign last           = status.emit_last;
endmodule

### hdl/cfp_ctrl.sv
module cfp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  cfp_pkg::status_t status,
    output cfp_pkg::cmd_t    cmd
);
    cfp_pkg::state_t state_reg, state_next;
    logic [5:0]      cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfp_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Each read address is presented in the cycle before its data is checked.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = cfp_pkg::OP_NONE;
        cmd.offset = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            cfp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = cfp_pkg::OP_WRITE;
                    state_next = cfp_pkg::ST_RD_SYNC;
                end
            end
            cfp_pkg::ST_RD_SYNC:
            begin
                // Load sync low byte, then present the high byte address.
                cmd.offset = cnt_reg;
                if (!status.have_two) state_next = cfp_pkg::ST_IDLE;
                else if (cnt_reg == 6'd0)
                begin
                    cnt_next = 6'd1;
                end
                else
                begin
                    cmd.op     = cfp_pkg::OP_READ_HDR;
                    cmd.offset = 6'd0;
                    state_next = cfp_pkg::ST_WRITE;
                end
            end
            cfp_pkg::ST_WRITE:
            begin
                // Present byte 1 so that sync can be compared next cycle.
                cmd.offset = 6'd1;
                state_next = cfp_pkg::ST_CHK_SYNC;
            end
            cfp_pkg::ST_CHK_SYNC:
            begin
                cnt_next = 6'd0;
                if (!status.sync_ok)
                begin
                    cmd.op     = cfp_pkg::OP_DROP1;
                    state_next = cfp_pkg::ST_RD_SYNC;
                end
                else if (!status.have_hdr) state_next = cfp_pkg::ST_IDLE;
                else
                begin
                    cmd.offset = 6'd2;
                    cnt_next   = 6'd2;
                    state_next = cfp_pkg::ST_RD_LEN;
                end
            end
            cfp_pkg::ST_RD_LEN:
            begin
                // Bytes 2..4 are captured, byte 5 is compared live.
                cmd.op     = cfp_pkg::OP_READ_HDR;
                cmd.offset = cnt_reg;
                if (cnt_reg == 6'd5) cmd.op = cfp_pkg::OP_NONE;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd4) state_next = cfp_pkg::ST_CHK_LEN;
                else                 cmd.offset = cnt_reg + 6'd1;
                if (cnt_reg == 6'd4) cmd.offset = 6'd5;
            end
            cfp_pkg::ST_CHK_LEN:
            begin
                cnt_next = 6'd0;
                if (!status.len_ok)
                begin
                    cmd.op     = cfp_pkg::OP_DROP2;
                    state_next = cfp_pkg::ST_RD_SYNC;
                end
                else if (!status.have_frame) state_next = cfp_pkg::ST_IDLE;
                else
                begin
                    cmd.op     = cfp_pkg::OP_CRC_INIT;
                    cmd.offset = 6'd0;
                    state_next = cfp_pkg::ST_CRC;
                end
            end
            cfp_pkg::ST_CRC:
            begin
                // One byte per cycle; address runs one ahead of the data.
                cmd.offset = cnt_reg + 6'd1;
                if (status.crc_done)
                begin
                    cmd.offset = cnt_reg;
                    state_next = cfp_pkg::ST_RD_CRC;
                end
                else
                begin
                    cmd.op   = cfp_pkg::OP_CRC_STEP;
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            cfp_pkg::ST_RD_CRC:
            begin
                cmd.op     = cfp_pkg::OP_READ_CRC;
                cmd.offset = cnt_reg + 6'd1;
                state_next = cfp_pkg::ST_CHK_CRC;
            end
            cfp_pkg::ST_CHK_CRC:
            begin
                cnt_next = 6'd0;
                if (!status.crc_ok)
                begin
                    cmd.op     = cfp_pkg::OP_DROP1;
                    state_next = cfp_pkg::ST_RD_SYNC;
                end
                else
                begin
                    cmd.op     = cfp_pkg::OP_EMIT_LOAD;
                    cmd.offset = 6'd7;
                    cnt_next   = 6'd6;
                    state_next = cfp_pkg::ST_EMIT_WAIT;
                end
            end
            cfp_pkg::ST_EMIT_WAIT:
            begin
                cmd.offset = cnt_reg;
                state_next = cfp_pkg::ST_EMIT;
            end
            cfp_pkg::ST_EMIT:
            begin
                // Read data is held by keeping the address steady.
                out_valid  = 1'b1;
                cmd.offset = cnt_reg;
                if (out_ready)
                begin
                    if (status.emit_last)
                    begin
                        cmd.op     = cfp_pkg::OP_DROP_FRAME;
                        cnt_next   = 6'd0;
                        state_next = cfp_pkg::ST_RD_SYNC;
                    end
                    else
                    begin
                        cmd.op     = cfp_pkg::OP_EMIT_LOAD;
                        cmd.offset = cnt_reg + 6'd2;
                        cnt_next   = cnt_reg + 6'd1;
                        state_next = cfp_pkg::ST_EMIT_WAIT;
                    end
                end
            end
            default: state_next = cfp_pkg::ST_IDLE;
        endcase
    end

    // Input is only taken while the controller is idle.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == cfp_pkg::ST_IDLE) else $error("ready outside idle");
    // A result is never shown while input is accepted.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input and output overlap");
    // An offered result stays until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result withdrawn");
endmodule

### hdl/crc16_frame_parser.sv
// A byte is taken while the controller is idle; the sync word is then checked, the header
// is read and checked, and a CRC pass runs over the header and payload bytes.
// Each result is held until taken, and each dropped byte leads to a rescan.
// No new byte is taken until the work for the last one is done, nor while a result is
// offered or a rescan follows a drop.
// Reset (rst_n, asynchronous): buffer empty, sync_word 0, max_payload_length 16.
module crc16_frame_parser (
    input  logic clk,
    input  logic rst_n,
    cfp_cfg_if.sink       cfg,
    cfp_stream_if.sink    in_data,
    cfp_out_if.source     result
);
    cfp_pkg::cmd_t    cmd;
    cfp_pkg::status_t status;
    logic [15:0]      sync_word_reg;
    logic [4:0]       max_len_reg;

    // Configuration registers.
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg <= 16'd0;
            max_len_reg   <= 5'd16;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                cfp_pkg::REG_SYNC_WORD:   sync_word_reg <= cfg.wdata;
                cfp_pkg::REG_MAX_PAYLOAD: max_len_reg   <= cfg.wdata[4:0];
                default: ;
            endcase
        end
    end

    cfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_data.valid),
        .in_ready  (in_data.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cfp_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_byte        (in_data.data),
        .sync_word      (sync_word_reg),
        .max_len        (max_len_reg),
        .device_id      (result.device_id),
        .function_code  (result.function_code),
        .payload_length (result.payload_length),
        .byte_index     (result.byte_index),
        .payload_byte   (result.payload_byte),
        .frame_empty    (result.frame_empty),
        .last           (result.last)
    );
endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    logic clk;
    logic rst_n;

    cfp_cfg_if        cfg_if ();
    cfp_stream_if #(8) in_if ();
    cfp_out_if        out_if ();

    crc16_frame_parser u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_if.sink),
        .in_data (in_if.sink),
        .result  (out_if.source)
    );

    // One decoded payload beat as the block should present it.
    typedef struct packed {
        logic [7:0] device_id;
        logic [7:0] function_code;
        logic [4:0] payload_length;
        logic [3:0] byte_index;
        logic [7:0] payload_byte;
        logic       frame_empty;
        logic       last;
    } beat_t;

    localparam int BUF_DEPTH = 32;
    localparam int PAYLOAD_CAP = 16;
    localparam int SETTLE_CYCLES = 400;

    // Shadow copy of the parser state.
    logic [7:0]  rx_buf [BUF_DEPTH];
    int          rx_fill;
    logic [15:0] cur_sync;
    logic [4:0]  cur_max_len;

    beat_t       pending_beats [$];
    int          error_count;
    int          beats_seen;
    bit          rx_hold;
    bit          sender_busy;

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shift the shadow buffer down by n bytes.
    function automatic void shadow_drop(input int n);
        if (n >= rx_fill)
        begin
            rx_fill = 0;
            return;
        end
        for (int i = 0; i < rx_fill - n; i++)
            rx_buf[i] = rx_buf[i + n];
        rx_fill -= n;
    endfunction

    function automatic logic [15:0] crc_over(input logic [7:0] bytes [], input int count);
        logic [15:0] crc;
        crc = 16'hFFFF;
        for (int i = 0; i < count; i++)
        begin
            crc ^= {8'h00, bytes[i]};
            for (int b = 0; b < 8; b++)
                crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
        end
        return crc;
    endfunction

    // Append one received byte and queue the payload beats of any frames it completes.
    task automatic predict_byte(input logic [7:0] b);
        int unsigned lim;
        int unsigned len;
        int size;
        logic [15:0] got;
        logic [15:0] want;
        logic [7:0] tmp [];
        beat_t bt;
        lim = (cur_max_len > PAYLOAD_CAP) ? PAYLOAD_CAP : cur_max_len;
        if (rx_fill >= BUF_DEPTH)
            shadow_drop(1);
        rx_buf[rx_fill] = b;
        rx_fill++;
        forever
        begin
            while (rx_fill >= 2 && {rx_buf[1], rx_buf[0]} != cur_sync)
                shadow_drop(1);
            if (rx_fill < cfp_pkg::HEADER_BYTES)
                break;
            len = {rx_buf[5], rx_buf[4]};
            if (len > lim)
            begin
                shadow_drop(2);
                continue;
            end
            size = cfp_pkg::HEADER_BYTES + len + cfp_pkg::CRC_BYTES;
            if (rx_fill < size)
                break;
            tmp = new[size];
            for (int i = 0; i < size; i++)
                tmp[i] = rx_buf[i];
            got = crc_over(tmp, size - cfp_pkg::CRC_BYTES);
            want = {rx_buf[size - 1], rx_buf[size - 2]};
            if (got != want)
            begin
                shadow_drop(1);
                continue;
            end
            bt.device_id = rx_buf[2];
            bt.function_code = rx_buf[3];
            if (len == 0)
            begin
                bt.payload_length = '0;
                bt.byte_index = '0;
                bt.payload_byte = '0;
                bt.frame_empty = 1'b1;
                bt.last = 1'b1;
                pending_beats.push_back(bt);
            end
            else
            begin
                for (int k = 0; k < len; k++)
                begin
                    bt.payload_length = len[4:0];
                    bt.byte_index = k[3:0];
                    bt.payload_byte = rx_buf[cfp_pkg::HEADER_BYTES + k];
                    bt.frame_empty = 1'b0;
                    bt.last = (k + 1 == len);
                    pending_beats.push_back(bt);
                end
            end
            shadow_drop(size);
        end
    endtask

    // Configuration writes, only issued while the block is idle.
    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.wdata <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == cfp_pkg::REG_SYNC_WORD)
            cur_sync = val;
        else
            cur_max_len = val[4:0];
    endtask

    // Send one byte; the beat is predicted on acceptance.
    task automatic send_byte(input logic [7:0] b);
        in_if.valid <= 1'b1;
        in_if.data  <= b;
        do
            @(posedge clk);
        while (!in_if.ready);
        predict_byte(b);
    endtask

    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return;
        in_if.valid <= 1'b0;
        if (r < 95)
            repeat ($urandom_range(1, 3)) @(posedge clk);
        else
            repeat ($urandom_range(20, 80)) @(posedge clk);
    endtask

    task automatic send_gapped(input logic [7:0] b);
        idle_gap();
        send_byte(b);
    endtask

    // Wait for every predicted beat (or a time-out), then let the block settle.
    task automatic drain();
        int waited;
        in_if.valid <= 1'b0;
        waited = 0;
        while (pending_beats.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Build a frame with the current sync word; optionally corrupt the CRC.
    task automatic send_frame(input logic [7:0] dev, input logic [7:0] fc,
                              input logic [15:0] len, input bit bad_crc);
        logic [7:0] fr [];
        logic [15:0] crc;
        int n;
        n = cfp_pkg::HEADER_BYTES + len + cfp_pkg::CRC_BYTES;
        fr = new[n];
        fr[0] = cur_sync[7:0];
        fr[1] = cur_sync[15:8];
        fr[2] = dev;
        fr[3] = fc;
        fr[4] = len[7:0];
        fr[5] = len[15:8];
        for (int i = 0; i < len; i++)
            fr[cfp_pkg::HEADER_BYTES + i] = 8'($urandom_range(0, 255));
        crc = crc_over(fr, n - cfp_pkg::CRC_BYTES);
        if (bad_crc)
            crc ^= 16'h0001 << $urandom_range(0, 15);
        fr[n - 2] = crc[7:0];
        fr[n - 1] = crc[15:8];
        for (int i = 0; i < n; i++)
            send_gapped(fr[i]);
    endtask

    // Directed table: device, function, length, corrupt flag.
    typedef struct {
        logic [7:0]  dev;
        logic [7:0]  fc;
        logic [15:0] len;
        bit          bad;
    } frame_row_t;

    frame_row_t dir_rows [] = '{
        '{8'h00, 8'h00, 16'd0,  1'b0},
        '{8'hFF, 8'hFF, 16'd16, 1'b0},
        '{8'h55, 8'hAA, 16'd1,  1'b0},
        '{8'h12, 8'h34, 16'd3,  1'b1},
        '{8'h01, 8'h80, 16'd17, 1'b0},
        '{8'h7E, 8'h03, 16'hFF00, 1'b0},
        '{8'hA5, 8'h5A, 16'd8,  1'b0}
    };

    // Receiver: random stalls, one long hold-off when asked, and the checker.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_if.ready <= 1'b0;
        else if (rx_hold)
            out_if.ready <= 1'b0;
        else
            out_if.ready <= ($urandom_range(0, 99) < 70) ||
                            ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        beat_t act;
        beat_t exp_b;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            act = '{out_if.device_id, out_if.function_code, out_if.payload_length,
                    out_if.byte_index, out_if.payload_byte, out_if.frame_empty,
                    out_if.last};
            beats_seen++;
            if (pending_beats.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected beat %p", act);
            end
            else
            begin
                exp_b = pending_beats.pop_front();
                if (act !== exp_b)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("beat mismatch: expected %p, got %p", exp_b, act);
                end
            end
        end
    end

    // Long hold-off on the receive side, counted in cycles.
    initial
    begin
        rx_hold = 1'b0;
        wait (sender_busy);
        repeat (300) @(posedge clk);
        rx_hold = 1'b1;
        repeat (600) @(posedge clk);
        rx_hold = 1'b0;
    end

    // Watchdog.
    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        logic [15:0] sync_set [4];
        logic [4:0]  max_set [4];
        rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = cfp_pkg::REG_SYNC_WORD;
        cfg_if.wdata = '0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        rx_fill = 0;
        cur_sync = 16'h0000;
        cur_max_len = 5'd16;
        error_count = 0;
        beats_seen = 0;
        sender_busy = 1'b0;
        sync_set = '{16'hB562, 16'h0000, 16'hFFFF, 16'h0102};
        max_set  = '{5'd16, 5'd0, 5'd31, 5'd5};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values first: sync 0, limit 16, an empty frame after zero noise.
        send_frame(8'h10, 8'h20, 16'd0, 1'b0);
        drain();

        write_reg(cfp_pkg::REG_SYNC_WORD, 16'hB562);
        for (int i = 0; i < dir_rows.size(); i++)
        begin
            if (dir_rows[i].len > 16'd64)
            begin
                // Huge length field: just the header; the next row follows directly.
                send_gapped(cur_sync[7:0]);
                send_gapped(cur_sync[15:8]);
                send_gapped(dir_rows[i].dev);
                send_gapped(dir_rows[i].fc);
                send_gapped(dir_rows[i].len[7:0]);
                send_gapped(dir_rows[i].len[15:8]);
            end
            else
                send_frame(dir_rows[i].dev, dir_rows[i].fc, dir_rows[i].len,
                           dir_rows[i].bad);
        end
        drain();

        // Random phases over several register settings.
        sender_busy = 1'b1;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(cfp_pkg::REG_SYNC_WORD, sync_set[ph]);
            write_reg(cfp_pkg::REG_MAX_PAYLOAD, {11'd0, max_set[ph]});
            for (int f = 0; f < 4; f++)
            begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 65)
                    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               (f == 0) ? 16'd16 : 16'($urandom_range(0, 4)), 1'b0);
                else if (r < 80)
                    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               16'($urandom_range(0, 6)), 1'b1);
                else
                    repeat ($urandom_range(1, 6)) send_gapped(8'($urandom_range(0, 255)));
            end
            drain();
        end

        in_if.valid <= 1'b0;
        drain();
        if (pending_beats.size() == 0 && error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### crc16_frame_parser.f
hdl/cfp_pkg.sv
hdl/cfp_stream_if.sv
hdl/cfp_cfg_if.sv
hdl/cfp_out_if.sv
hdl/cfp_ram.sv
hdl/cfp_datapath.sv
hdl/cfp_ctrl.sv
hdl/crc16_frame_parser.sv
dv/tb_top.sv
